[sv/prt_pkg.sv]
// Shared types and codes for the port range table.
package prt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_COLL   = 2'd2;
   localparam logic [1:0] CMD_EXISTS = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_COLLIDE  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] first_port;
      logic [15:0] range_size;
      logic        protocol;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       hit;
      logic [4:0] entries_used;
   } rsp_type;

   // Stored ranges keep their last port rather than their length.
   typedef struct packed {
      logic        proto;
      logic [15:0] start;
      logic [15:0] last_port;
   } entry_type;

   typedef struct packed {
      logic overlap;
      logic exact;
   } match_type;

endpackage

[sv/prt_table.sv]
// Entry RAM with registered read port, per-entry valid flops and fill count.
module prt_table #(
   parameter int DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic                                  clr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
   input  prt_pkg::entry_type                    wr_entry,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
   output prt_pkg::entry_type                    rd_entry,
   output logic                                  rd_live,
   output logic                                  rd_free,
   output logic [$clog2(DEPTH+1)-1:0]            used
);
   import prt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              mem [DEPTH];
   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   entry_type              rd_entry_ff;
   logic                   rd_live_ff;

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
         used_in          = used_ff + CNT_W'(1);
      end else if (clr_en) begin
         valid_in[wr_idx] = 1'b0;
         used_in          = used_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_live  = rd_live_ff;
   assign rd_free  = ~valid_ff[rd_idx];
   assign used     = used_ff;

endmodule

[sv/prt_cmp.sv]
// Shared range compare: overlap and exact match of one stored entry against the request.
module prt_cmp (
   input  prt_pkg::entry_type key,
   input  prt_pkg::entry_type entry,
   input  logic               live,
   output prt_pkg::match_type match
);
   import prt_pkg::*;

   logic same_proto;

   assign same_proto    = live && (entry.proto == key.proto);
   assign match.overlap = same_proto && (entry.start <= key.last_port)
                          && (key.start <= entry.last_port);
   // Same start and same last port means same length.
   assign match.exact   = same_proto && (entry.start == key.start)
                          && (entry.last_port == key.last_port);

endmodule

[sv/port_range_table_core.sv]
// Port range table: a request is checked against every stored range by a one-entry-per-cycle
// scan through the entry RAM's single read port and one shared compare unit. A valid request
// returns its result after the scan and the S_LAST and S_APPLY states; a request with an empty
// range or one whose last port would be 65535 or above is answered in the next cycle. The
// block takes one request at a time: req_ready is high only when no request is in work and no
// result waits on the rsp channel, so a new request can be accepted the cycle after the result
// is taken. Adds go to the lowest free slot; entries_used is the count after the request.
module port_range_table_core #(
   parameter int DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prt_pkg::rsp_type rsp_data
);
   import prt_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_LAST  = 5'b00100,
      S_APPLY = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   entry_type        key_ff, key_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             overlap_ff, overlap_in;
   logic             exact_ff, exact_in;
   logic [IDX_W-1:0] exact_idx_ff, exact_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [2:0]       status_ff, status_in;
   logic             hit_ff, hit_in;

   logic             req_fire;
   logic [16:0]      port_sum;
   logic             bad_range;
   logic             wr_en, clr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        rd_entry;
   logic             rd_live, rd_free;
   logic [CNT_W-1:0] used;
   match_type        match;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign req_fire  = req_valid && req_ready;

   assign port_sum  = {1'b0, req_data.first_port} + {1'b0, req_data.range_size};
   assign bad_range = (req_data.range_size == 16'd0) || port_sum[16];

   prt_table #(
      .DEPTH(DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .clr_en   (clr_en),
      .wr_idx   (wr_idx),
      .wr_entry (key_ff),
      .rd_idx   (rd_idx_ff),
      .rd_entry (rd_entry),
      .rd_live  (rd_live),
      .rd_free  (rd_free),
      .used     (used)
   );

   prt_cmp u_cmp (
      .key   (key_ff),
      .entry (rd_entry),
      .live  (rd_live),
      .match (match)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = rd_idx_ff;
      overlap_in   = overlap_ff;
      exact_in     = exact_ff;
      exact_idx_in = exact_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      wr_en        = 1'b0;
      clr_en       = 1'b0;
      wr_idx       = free_idx_ff;

      // Compare stage: entry read last cycle is on the RAM output now.
      if (cmp_vld_ff) begin
         if (match.overlap) begin
            overlap_in = 1'b1;
         end
         if (match.exact && !exact_ff) begin
            exact_in     = 1'b1;
            exact_idx_in = cmp_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in          = req_data.command;
               key_in.proto    = req_data.protocol;
               key_in.start    = req_data.first_port;
               key_in.last_port = port_sum[15:0] - 16'd1;
               rd_idx_in       = '0;
               overlap_in      = 1'b0;
               exact_in        = 1'b0;
               free_in         = 1'b0;
               status_in       = ST_OK;
               hit_in          = 1'b0;
               if (bad_range) begin
                  status_in = ST_INVALID;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (rd_free && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            if (rd_idx_ff == IDX_W'(DEPTH - 1)) begin
               state_in = S_LAST;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         S_LAST: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_ADD: begin
                  if (overlap_ff) begin
                     status_in = ST_COLLIDE;
                  end else if (!free_ff) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
               CMD_DELETE: begin
                  wr_idx = exact_idx_ff;
                  if (exact_ff) begin
                     clr_en = 1'b1;
                  end else begin
                     status_in = ST_NOTFOUND;
                  end
               end
               CMD_COLL: begin
                  hit_in = overlap_ff;
               end
               CMD_EXISTS: begin
                  hit_in = exact_ff;
               end
               default: begin
                  hit_in = 1'b0;
               end
            endcase
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      overlap_ff   <= overlap_in;
      exact_ff     <= exact_in;
      exact_idx_ff <= exact_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      status_ff    <= status_in;
      hit_ff       <= hit_in;
   end

   assign rsp_data.status       = status_ff;
   assign rsp_data.hit          = hit_ff;
   assign rsp_data.entries_used = 5'(used);

endmodule

[sv/prt_checker.sv]
// Port-level checks for the port range table, bound to the top level.
module prt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input prt_pkg::rsp_type rsp_data
);
   import prt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in work");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_invalid_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_INVALID) |-> !rsp_data.hit)
      else $error("hit set on an invalid range");

   a_hit_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.status == ST_OK)
      else $error("hit set with an error status");

endmodule

bind port_range_table_core prt_checker u_prt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/sv/port_range_table_core_test.sv]
// Self-checking testbench for port_range_table_core: directed request table, then random traffic.
`timescale 1ns / 1ps

module port_range_table_core_test;
   import prt_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam logic PROTO_TCP = 1'b0;
   localparam logic PROTO_UDP = 1'b1;
   localparam int RANDOM_PER_PHASE = 310;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Shadow copy of the range table
   logic        tbl_valid [DEPTH];
   logic [15:0] tbl_start [DEPTH];
   logic [15:0] tbl_len   [DEPTH];
   logic        tbl_proto [DEPTH];

   rsp_type      expected_rsp_q [$];
   stim_row_type dir_rows [$];
   int           err_count;
   int           send_idle;
   int           rcv_idle;

   port_range_table_core #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic bit range_overlap(logic [15:0] s1, logic [15:0] l1,
                                        logic [15:0] s2, logic [15:0] l2);
      logic [16:0] e1;
      logic [16:0] e2;
      e1 = {1'b0, s1} + l1 - 17'd1;
      e2 = {1'b0, s2} + l2 - 17'd1;
      return ({1'b0, s1} <= e2) && ({1'b0, s2} <= e1);
   endfunction

   function automatic bit table_overlap(logic [15:0] s, logic [15:0] l, logic p);
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_proto[i] == p && range_overlap(tbl_start[i], tbl_len[i], s, l))
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic int exact_slot(logic [15:0] s, logic [15:0] l, logic p);
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_proto[i] == p && tbl_start[i] == s && tbl_len[i] == l)
            return i;
      return DEPTH;
   endfunction

   // Applies one request to the shadow table and returns its result.
   function automatic rsp_type predict_range(req_type r);
      rsp_type res;
      int      slot;
      int      used;
      res = '0;
      res.status = ST_OK;
      slot = DEPTH;
      used = 0;
      if (r.range_size == 16'd0 || ({1'b0, r.first_port} + r.range_size) > 17'd65535) begin
         res.status = ST_INVALID;
      end else if (r.command == CMD_ADD) begin
         if (table_overlap(r.first_port, r.range_size, r.protocol)) begin
            res.status = ST_COLLIDE;
         end else begin
            for (int i = DEPTH - 1; i >= 0; i--)
               if (!tbl_valid[i]) slot = i;
            if (slot >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               tbl_valid[slot] = 1'b1;
               tbl_start[slot] = r.first_port;
               tbl_len[slot]   = r.range_size;
               tbl_proto[slot] = r.protocol;
            end
         end
      end else if (r.command == CMD_DELETE) begin
         slot = exact_slot(r.first_port, r.range_size, r.protocol);
         if (slot >= DEPTH) res.status = ST_NOTFOUND;
         else tbl_valid[slot] = 1'b0;
      end else if (r.command == CMD_COLL) begin
         res.hit = table_overlap(r.first_port, r.range_size, r.protocol);
      end else begin
         res.hit = exact_slot(r.first_port, r.range_size, r.protocol) < DEPTH;
      end
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i]) used++;
      res.entries_used = used[4:0];
      return res;
   endfunction

   // Ranges packed into two narrow windows so adds and queries collide often.
   function automatic void fill_window(inout req_type r);
      bit upper;
      upper = $urandom_range(3) == 0;
      r.first_port = (upper ? 16'd64500 : 16'd0) + 16'($urandom_range(1023));
      r.range_size = 16'($urandom_range(1, 64));
      r.protocol   = 1'($urandom_range(1));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      sel;
      int      k;
      int      picks [$];
      r = '0;
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i]) picks = {picks, i};
      k = (picks.size() > 0) ? picks[$urandom_range(picks.size() - 1)] : 0;
      sel = $urandom_range(99);
      if (sel < 10) begin
         r.command    = 2'($urandom_range(3));
         r.first_port = 16'($urandom);
         r.range_size = 16'($urandom);
         r.protocol   = 1'($urandom_range(1));
         if ($urandom_range(1)) begin
            // end of range exactly at the top port, or one below it
            r.range_size = 16'($urandom_range(1, 16));
            r.first_port = 16'(65535 - r.range_size + $urandom_range(1));
         end
      end else if (sel < 40) begin
         r.command = CMD_ADD;
         fill_window(r);
      end else if (sel < 60) begin
         r.command = CMD_DELETE;
         if (picks.size() > 0) begin
            r.first_port = tbl_start[k];
            r.range_size = tbl_len[k];
            r.protocol   = tbl_proto[k];
         end else begin
            fill_window(r);
         end
      end else if (sel < 70) begin
         r.command = $urandom_range(1) ? CMD_DELETE : CMD_EXISTS;
         if (picks.size() > 0) begin
            r.first_port = tbl_start[k];
            r.range_size = tbl_len[k];
            r.protocol   = tbl_proto[k];
            case ($urandom_range(2))
               0: r.range_size = r.range_size + 16'd1;
               1: r.range_size = r.range_size - 16'd1;
               default: r.protocol = ~r.protocol;
            endcase
         end else begin
            fill_window(r);
         end
      end else if (sel < 85) begin
         r.command = CMD_COLL;
         fill_window(r);
      end else begin
         r.command = CMD_EXISTS;
         if (picks.size() > 0 && $urandom_range(1)) begin
            r.first_port = tbl_start[k];
            r.range_size = tbl_len[k];
            r.protocol   = tbl_proto[k];
         end else begin
            fill_window(r);
         end
      end
      return r;
   endfunction

   task automatic add_row(logic [1:0] cmd, logic [15:0] port, logic [15:0] size, logic proto,
                          bit typed, logic [2:0] st, logic hit, logic [4:0] used);
      stim_row_type row;
      row.req.command    = cmd;
      row.req.first_port = port;
      row.req.range_size = size;
      row.req.protocol   = proto;
      row.typed          = typed;
      row.rsp.status       = st;
      row.rsp.hit          = hit;
      row.rsp.entries_used = used;
      dir_rows = {dir_rows, row};
   endtask

   task automatic send_item(req_type r, bit typed, rsp_type fixed);
      rsp_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      pred = predict_range(r);
      expected_rsp_q = {expected_rsp_q, (typed ? fixed : pred)};
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      wait (expected_rsp_q.size() == 0);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = $urandom_range(99) >= rcv_idle;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            err_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.hit !== exp_rsp.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, exp_rsp.hit, rsp_data.hit);
               err_count++;
            end
            if (rsp_data.entries_used !== exp_rsp.entries_used) begin
               $display("%0t: entries_used expected %0d actual %0d",
                        $time, exp_rsp.entries_used, rsp_data.entries_used);
               err_count++;
            end
         end
      end
   end

   initial begin
      rsp_type none;
      none      = '0;
      err_count = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      send_idle = 24;
      rcv_idle  = 46;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_start[i] = '0;
         tbl_len[i]   = '0;
         tbl_proto[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(CMD_EXISTS, 16'd0, 16'd1, PROTO_TCP, 1'b1, ST_OK, 1'b0, 5'd0);
      add_row(CMD_ADD, 16'd0, 16'd0, PROTO_TCP, 1'b1, ST_INVALID, 1'b0, 5'd0);
      add_row(CMD_COLL, 16'd65535, 16'd1, PROTO_UDP, 1'b1, ST_INVALID, 1'b0, 5'd0);
      add_row(CMD_EXISTS, 16'hFFFF, 16'hFFFF, PROTO_UDP, 1'b1, ST_INVALID, 1'b0, 5'd0);
      add_row(CMD_ADD, 16'd0, 16'd65535, PROTO_TCP, 1'b1, ST_OK, 1'b0, 5'd1);
      add_row(CMD_COLL, 16'd65534, 16'd1, PROTO_TCP, 1'b1, ST_OK, 1'b1, 5'd1);
      add_row(CMD_ADD, 16'd0, 16'd65535, PROTO_UDP, 1'b1, ST_OK, 1'b0, 5'd2);
      add_row(CMD_DELETE, 16'd0, 16'd65534, PROTO_UDP, 1'b1, ST_NOTFOUND, 1'b0, 5'd2);
      add_row(CMD_DELETE, 16'd0, 16'd65535, PROTO_TCP, 1'b1, ST_OK, 1'b0, 5'd1);
      add_row(CMD_EXISTS, 16'd0, 16'd65535, PROTO_UDP, 1'b1, ST_OK, 1'b1, 5'd1);
      add_row(CMD_DELETE, 16'd100, 16'd10, PROTO_TCP, 1'b1, ST_NOTFOUND, 1'b0, 5'd1);
      for (int i = 0; i < DEPTH - 1; i++)
         add_row(CMD_ADD, 16'(100 * i + 100), 16'd50, PROTO_TCP, 1'b0, ST_OK, 1'b0, 5'd0);
      add_row(CMD_ADD, 16'd40000, 16'd5, PROTO_TCP, 1'b1, ST_FULL, 1'b0, 5'd16);
      // overlap wins over a full table
      add_row(CMD_ADD, 16'd120, 16'd1, PROTO_TCP, 1'b1, ST_COLLIDE, 1'b0, 5'd16);

      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 24 : (phase == 1) ? 46 : 0;
         rcv_idle  = (phase == 0) ? 46 : (phase == 1) ? 24 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_item(random_request(), 1'b0, none);
            if ($urandom_range(49) == 0) drain_results();
         end
         drain_results();
      end

      repeat (DEPTH + 20) @(posedge clock);
      if (err_count == 0 && expected_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
